[rtl/core/lfucl_pkg.sv]
// Shared constants, entry layout and sequencer states for the LFU store.
package lfucl_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int SCAN_W      = IDX_W + 1;
	localparam int COUNT_W     = 16;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CAP_W       = 5;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [COUNT_W-1:0] count;
		logic [IDX_W-1:0]   rank;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPD,
		ST_DONE
	} state_t;

endpackage

[rtl/core/lfu_cache_lru_tiebreak.sv]
// Top level: LFU key-value store with LRU tie-break, built around one entry RAM.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: mode (0 get, 1 put),
//   key and write_value. Output channel (out_valid/out_ready) returns one
//   item per input: hit and read_value (value on a get hit, else zero).
//   cfg_we/cfg_wdata write the capacity register; write it only while idle.
//   One item is in work at a time; the next item can be taken in the
//   cycle after the result loads. Each access makes a scan pass over the
//   16 RAM entries through its single read port for key match and
//   eviction victim. Every access but a get miss or an insert with
//   capacity zero changes the store and then makes a read-modify-write
//   pass that shifts recency ranks and writes the target.
//   Reset clears all valid bits, occupancy and the result valid flag and
//   sets capacity to 16; no clearing pass is needed.
//   A result waiting on a stalled receiver is held in the output register;
//   the next item is accepted meanwhile and parks in its final state until
//   the register frees.
module lfu_cache_lru_tiebreak (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [lfucl_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     mode,
	input  logic [lfucl_pkg::KEY_W-1:0] key,
	input  logic [lfucl_pkg::VAL_W-1:0] write_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     hit,
	output logic [lfucl_pkg::VAL_W-1:0] read_value
);
	import lfucl_pkg::*;

	state_t state_q, state_d;

	logic [CAP_W-1:0]   capacity_q;
	logic [CAP_W-1:0]   occ_q;
	logic [MAX_ENTRIES-1:0] valid_q;

	logic               mode_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   wval_q;

	logic [SCAN_W-1:0]  cnt_q;
	logic               chk_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic               found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [VAL_W-1:0]   hit_val_q;
	logic [COUNT_W-1:0] hit_cnt_q;
	logic [IDX_W-1:0]   hit_rank_q;

	logic               vic_any_q;
	logic [IDX_W-1:0]   vic_idx_q;
	logic [COUNT_W-1:0] vic_cnt_q;
	logic [IDX_W-1:0]   vic_rank_q;

	logic               shift_q;
	logic [IDX_W-1:0]   tgt_q;
	logic [IDX_W-1:0]   r_q;
	entry_t             new_q;
	logic               res_hit_q;
	logic [VAL_W-1:0]   res_val_q;

	logic               out_valid_q;
	logic               hit_q;
	logic [VAL_W-1:0]   read_value_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	logic               ram_re;
	entry_t             ram_rdata;
	logic [ENTRY_W-1:0] ram_rbits;

	logic               accept;
	logic               pass_end;
	logic               res_load;
	logic [CAP_W-1:0]   cap_eff;
	logic               ent_ok;
	logic               do_write;
	logic [IDX_W-1:0]   free_idx;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign pass_end  = (cnt_q == SCAN_W'(MAX_ENTRIES));
	assign res_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign cap_eff   = (capacity_q > CAP_W'(MAX_ENTRIES)) ? CAP_W'(MAX_ENTRIES) : capacity_q;
	assign ram_re    = ((state_q == ST_SCAN) || (state_q == ST_UPD)) && !pass_end;
	assign ram_rdata = entry_t'(ram_rbits);
	assign ent_ok    = chk_s1 && valid_q[idx_s1];
	assign do_write  = found_q || (mode_q && (cap_eff != '0));

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

	// Entry storage
	lfucl_ram #(
		.DATA_W (ENTRY_W),
		.DEPTH  (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (ram_rbits)
	);

	// Lowest-numbered free slot
	always_comb begin
		free_idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// Update pass write-back: target gets the new entry, later ranks step down
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = ram_rdata;
		if ((state_q == ST_UPD) && chk_s1) begin
			if (idx_s1 == tgt_q) begin
				ram_we    = 1'b1;
				ram_wdata = new_q;
			end else if (ent_ok && shift_q && (ram_rdata.rank > r_q)) begin
				ram_we         = 1'b1;
				ram_wdata.rank = ram_rdata.rank - 1'b1;
			end
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_SCAN;
			ST_SCAN:   if (pass_end) state_d = ST_DECIDE;
			ST_DECIDE: state_d = do_write ? ST_UPD : ST_DONE;
			ST_UPD:    if (pass_end) state_d = ST_DONE;
			ST_DONE:   if (res_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control registers: capacity, valid bits, occupancy, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_W'(MAX_ENTRIES);
			occ_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			chk_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			// insert into a free slot
			if ((state_q == ST_DECIDE) && !found_q && mode_q && (cap_eff != '0)
					&& (occ_q < cap_eff)) begin
				valid_q[free_idx] <= 1'b1;
				occ_q             <= occ_q + 1'b1;
			end
			// advance the pass counter
			chk_s1 <= ram_re;
			if ((state_q == ST_SCAN) || (state_q == ST_UPD)) begin
				cnt_q <= pass_end ? '0 : cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			// hold the result until taken
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (accept) begin
			mode_q    <= mode;
			key_q     <= key;
			wval_q    <= write_value;
			found_q   <= 1'b0;
			vic_any_q <= 1'b0;
		end
		// scan: key match and victim search
		if ((state_q == ST_SCAN) && ent_ok) begin
			if (!found_q && (ram_rdata.key == key_q)) begin
				found_q    <= 1'b1;
				hit_idx_q  <= idx_s1;
				hit_val_q  <= ram_rdata.value;
				hit_cnt_q  <= ram_rdata.count;
				hit_rank_q <= ram_rdata.rank;
			end
			if (!vic_any_q || (ram_rdata.count < vic_cnt_q) ||
					((ram_rdata.count == vic_cnt_q) && (ram_rdata.rank < vic_rank_q))) begin
				vic_any_q  <= 1'b1;
				vic_idx_q  <= idx_s1;
				vic_cnt_q  <= ram_rdata.count;
				vic_rank_q <= ram_rdata.rank;
			end
		end
		// decide the target and the new entry
		if (state_q == ST_DECIDE) begin
			res_hit_q <= found_q;
			res_val_q <= (found_q && !mode_q) ? hit_val_q : '0;
			new_q.key <= key_q;
			if (found_q) begin
				tgt_q       <= hit_idx_q;
				r_q         <= hit_rank_q;
				shift_q     <= 1'b1;
				new_q.rank  <= IDX_W'(occ_q - 1'b1);
				new_q.value <= mode_q ? wval_q : hit_val_q;
				new_q.count <= (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
			end else begin
				new_q.value <= wval_q;
				new_q.count <= COUNT_W'(1);
				if (occ_q >= cap_eff) begin
					tgt_q      <= vic_idx_q;
					r_q        <= vic_rank_q;
					shift_q    <= 1'b1;
					new_q.rank <= IDX_W'(occ_q - 1'b1);
				end else begin
					tgt_q      <= free_idx;
					r_q        <= '0;
					shift_q    <= 1'b0;
					new_q.rank <= IDX_W'(occ_q);
				end
			end
		end
		if (res_load) begin
			hit_q        <= res_hit_q;
			read_value_q <= res_val_q;
		end
	end

endmodule

[rtl/core/lfucl_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
module lfucl_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/lfucl_checker.sv]
// Port-level checks for the LFU store, bound to the top level.
module lfucl_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     hit,
	input logic [lfucl_pkg::VAL_W-1:0] read_value
);
	import lfucl_pkg::*;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value))
		else $error("result changed while stalled");

	// A miss returns zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> read_value == '0)
		else $error("miss with nonzero value");

	// One item in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// No result follows acceptance in the next cycle unless one was waiting
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
		else $error("result too early");

endmodule

bind lfu_cache_lru_tiebreak lfucl_checker u_lfucl_checker (.*);
